// ===== design/sacp_pkg.sv =====
package sacp_pkg;

    // Register indexes of the configuration port.
    typedef enum logic [2:0] {
        REG_OFFSET   = 3'd0,
        REG_INDEX    = 3'd1,
        REG_WAYS     = 3'd2,
        REG_POLICY   = 3'd3,
        REG_PREFETCH = 3'd4
    } reg_idx_t;

    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_LRU  = 1'b1;

    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

    // Control from the sequencer to the set store.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } set_ctl_t;

endpackage

// ===== design/sacp_set_store.sv =====
// Set store: one row per set holding every way's valid bit, age and tag.
// Read data is registered. A row is cleared by writing it with all valid bits low.
module sacp_set_store #(
    parameter int SETS  = 1024,
    parameter int ROW_W = 8
) (
    input  logic                    clk,
    input  sacp_pkg::set_ctl_t      ctl,
    input  logic [$clog2(SETS)-1:0] rd_addr,
    input  logic [$clog2(SETS)-1:0] wr_addr,
    input  logic [ROW_W-1:0]        wr_data,
    output logic [ROW_W-1:0]        rd_data
);

    logic [ROW_W-1:0] mem [SETS];

    // Synchronous write port.
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Synchronous read port.
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/set_assoc_cache_with_prefetch.sv =====
// Channel   Direction  Payload
// s_axis    in         tdata: address[47:0], cmd[48]
// m_axis    out        tdata: hit, reads_caused, hit/miss/read/write totals
// apb       in/out     five configuration registers at 4*i
//
// An item is accepted, then each lookup has a read state and a state waiting
// for the registered read data. A FIFO demand hit or a prefetch hit then needs
// one output step, an LRU demand hit adds a write-back first, and a miss evicts
// the oldest lines one at a time, then takes an insert, a write-back and the
// output step. A demand miss is followed by up to prefetch_count prefetch
// lookups. After reset a clearing pass writes every set row once before the
// first transfer is taken. A waiting result does not block the next transfer
// being accepted; the next result waits for it.
module set_assoc_cache_with_prefetch #(
    parameter int SET_BITS_MAX = 10,
    parameter int WAYS_MAX     = 8,
    parameter int ADDR_BITS    = 48,
    parameter int PREFETCH_MAX = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // tdata: address, cmd
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [((ADDR_BITS+1+7)/8)*8-1:0] s_axis_tdata,
    // tdata: hit, reads_caused[3:0], hit_total, miss_total, read_total, write_total
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [135:0]         m_axis_tdata,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int SETS   = 1 << SET_BITS_MAX;
    localparam int SIDX_W = (SET_BITS_MAX > 0) ? SET_BITS_MAX : 1;
    localparam int AGE_W  = (WAYS_MAX > 1) ? $clog2(WAYS_MAX) : 1;
    localparam int VCNT_W = $clog2(WAYS_MAX + 1);
    localparam int WAY_W  = 1 + AGE_W + ADDR_BITS;
    localparam int ROW_W  = WAYS_MAX * WAY_W;
    localparam int WIDX_W = (WAYS_MAX > 1) ? $clog2(WAYS_MAX) : 1;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_READ, ST_WAIT, ST_EVICT, ST_WRITE, ST_OUT
    } state_t;

    typedef struct packed {
        logic             valid;
        logic [AGE_W-1:0] age;
        logic [ADDR_BITS-1:0] tag;
    } way_t;

    // Configuration registers.
    logic [4:0] offset_bits_reg;
    logic [3:0] index_bits_reg;
    logic [3:0] ways_in_use_reg;
    logic       replace_policy_reg;
    logic [3:0] prefetch_count_reg;

    state_t                 state_reg;
    logic [SIDX_W:0]        clr_reg;
    logic [ADDR_BITS-1:0]   addr_reg;
    logic                   demand_reg;
    logic [5:0]             pf_left_reg;
    logic                   hit_reg;
    logic [3:0]             reads_reg;
    logic [31:0]            hit_cnt_reg, miss_cnt_reg, read_cnt_reg, write_cnt_reg;
    way_t [WAYS_MAX-1:0]    row_reg;
    logic [SIDX_W-1:0]      set_reg;
    logic [ADDR_BITS-1:0]   tag_reg;
    logic                   out_valid_reg;
    logic [135:0]           out_data_reg;

    sacp_pkg::set_ctl_t     ctl;
    logic [ROW_W-1:0]       rd_data;
    logic [SIDX_W-1:0]      wr_addr;
    logic [ROW_W-1:0]       wr_data;

    assign pready = 1'b1;

    // Register reads.
    always_comb
    begin
        unique case (paddr[4:2])
            sacp_pkg::REG_OFFSET:   prdata = {27'd0, offset_bits_reg};
            sacp_pkg::REG_INDEX:    prdata = {28'd0, index_bits_reg};
            sacp_pkg::REG_WAYS:     prdata = {28'd0, ways_in_use_reg};
            sacp_pkg::REG_POLICY:   prdata = {31'd0, replace_policy_reg};
            sacp_pkg::REG_PREFETCH: prdata = {28'd0, prefetch_count_reg};
            default:                prdata = 32'd0;
        endcase
    end

    // Geometry decode.
    logic [4:0]            ib_used;
    logic [5:0]            sh_tag;
    logic [ADDR_BITS-1:0]  blk;
    logic [SIDX_W-1:0]     cur_set;
    logic [ADDR_BITS-1:0]  cur_tag;
    logic [3:0]            ways_used;
    logic [5:0]            pf_used;

    always_comb
    begin
        ib_used = (32'(index_bits_reg) > SET_BITS_MAX) ? 5'(SET_BITS_MAX)
                                                         : {1'b0, index_bits_reg};
        sh_tag  = 6'(offset_bits_reg) + 6'(ib_used);
        blk     = addr_reg >> offset_bits_reg;
        cur_set = SIDX_W'(blk & ((ADDR_BITS'(1) << ib_used) - ADDR_BITS'(1)));
        if (SET_BITS_MAX == 0)
        begin
            cur_set = '0;
        end
        cur_tag = addr_reg >> sh_tag;
        ways_used = (ways_in_use_reg == 4'd0) ? 4'd1 : ways_in_use_reg;
        if (32'(ways_used) > WAYS_MAX)
        begin
            ways_used = 4'(WAYS_MAX);
        end
        pf_used = (32'(prefetch_count_reg) > PREFETCH_MAX) ? 6'(PREFETCH_MAX)
                                                             : 6'(prefetch_count_reg);
    end

    // Lookup over the row just read.
    way_t [WAYS_MAX-1:0] rd_row;
    logic                look_hit;
    logic [WIDX_W-1:0]   hit_way;
    assign rd_row = rd_data;

    always_comb
    begin
        look_hit = 1'b0;
        hit_way  = '0;
        for (int w = WAYS_MAX - 1; w >= 0; w--)
        begin
            if (rd_row[w].valid && rd_row[w].tag == cur_tag)
            begin
                look_hit = 1'b1;
                hit_way  = WIDX_W'(w);
            end
        end
    end

    // LRU promotion of a demand hit.
    way_t [WAYS_MAX-1:0] lru_row;
    always_comb
    begin
        lru_row = rd_row;
        for (int w = 0; w < WAYS_MAX; w++)
        begin
            if (rd_row[w].valid && rd_row[w].age < rd_row[hit_way].age)
            begin
                lru_row[w].age = rd_row[w].age + AGE_W'(1);
            end
        end
        lru_row[hit_way].age = '0;
    end

    // Eviction of one oldest line per cycle while the set is full.
    logic [VCNT_W-1:0]   vcount;
    logic [WIDX_W-1:0]   old_way;
    logic                old_found;
    always_comb
    begin
        vcount    = '0;
        old_way   = '0;
        old_found = 1'b0;
        for (int w = 0; w < WAYS_MAX; w++)
        begin
            if (row_reg[w].valid)
            begin
                vcount = vcount + VCNT_W'(1);
                if (!old_found || row_reg[w].age > row_reg[old_way].age)
                begin
                    old_way = WIDX_W'(w);
                end
                old_found = 1'b1;
            end
        end
    end

    // Insertion into a row with room.
    way_t [WAYS_MAX-1:0] ins_row;
    logic                slot_found;
    logic [WIDX_W-1:0]   slot;
    always_comb
    begin
        ins_row    = row_reg;
        slot_found = 1'b0;
        slot       = '0;
        for (int w = 0; w < WAYS_MAX; w++)
        begin
            if (row_reg[w].valid)
            begin
                ins_row[w].age = row_reg[w].age + AGE_W'(1);
            end
            else if (!slot_found)
            begin
                slot_found = 1'b1;
                slot       = WIDX_W'(w);
            end
        end
        ins_row[slot].valid = 1'b1;
        ins_row[slot].tag   = tag_reg;
        ins_row[slot].age   = '0;
    end

    // Store control.
    always_comb
    begin
        ctl.rd_en = (state_reg == ST_READ);
        ctl.wr_en = (state_reg == ST_CLEAR) || (state_reg == ST_WRITE);
        wr_addr   = (state_reg == ST_CLEAR) ? clr_reg[SIDX_W-1:0] : set_reg;
        wr_data   = (state_reg == ST_CLEAR) ? '0 : ROW_W'(row_reg);
    end

    sacp_set_store #(
        .SETS  (SETS),
        .ROW_W (ROW_W)
    ) u_store (
        .clk     (clk),
        .ctl     (ctl),
        .rd_addr (cur_set),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Output step: either another prefetch lookup or loading the result.
    logic pf_next;
    logic out_load;
    assign pf_next  = (pf_left_reg != '0) && !(demand_reg && hit_reg);
    assign out_load = (state_reg == ST_OUT) && !pf_next && (!out_valid_reg || m_axis_tready);

    // Sequencer, counters and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_CLEAR;
            clr_reg            <= '0;
            offset_bits_reg    <= 5'd6;
            index_bits_reg     <= 4'd6;
            ways_in_use_reg    <= 4'd1;
            replace_policy_reg <= sacp_pkg::POLICY_FIFO;
            prefetch_count_reg <= 4'd0;
            hit_cnt_reg        <= '0;
            miss_cnt_reg       <= '0;
            read_cnt_reg       <= '0;
            write_cnt_reg      <= '0;
            out_valid_reg      <= 1'b0;
            demand_reg         <= 1'b0;
            pf_left_reg        <= '0;
            hit_reg            <= 1'b0;
            reads_reg          <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                unique case (paddr[4:2])
                    sacp_pkg::REG_OFFSET:   offset_bits_reg    <= pwdata[4:0];
                    sacp_pkg::REG_INDEX:    index_bits_reg     <= pwdata[3:0];
                    sacp_pkg::REG_WAYS:     ways_in_use_reg    <= pwdata[3:0];
                    sacp_pkg::REG_POLICY:   replace_policy_reg <= pwdata[0];
                    sacp_pkg::REG_PREFETCH: prefetch_count_reg <= pwdata[3:0];
                    default: ;
                endcase
            end
            if (out_valid_reg && m_axis_tready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + (SIDX_W+1)'(1);
                    if (32'(clr_reg) == SETS - 1)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        addr_reg   <= s_axis_tdata[ADDR_BITS-1:0];
                        demand_reg <= 1'b1;
                        reads_reg  <= '0;
                        if (s_axis_tdata[ADDR_BITS] && write_cnt_reg != sacp_pkg::CNT_MAX)
                        begin
                            write_cnt_reg <= write_cnt_reg + 32'd1;
                        end
                        state_reg <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    set_reg   <= cur_set;
                    tag_reg   <= cur_tag;
                    state_reg <= ST_WAIT;
                end
                ST_WAIT:
                begin
                    if (demand_reg)
                    begin
                        hit_reg <= look_hit;
                        if (look_hit)
                        begin
                            if (hit_cnt_reg != sacp_pkg::CNT_MAX)
                            begin
                                hit_cnt_reg <= hit_cnt_reg + 32'd1;
                            end
                            if (replace_policy_reg == sacp_pkg::POLICY_LRU)
                            begin
                                row_reg   <= lru_row;
                                state_reg <= ST_WRITE;
                            end
                            else
                            begin
                                row_reg   <= rd_row;
                                state_reg <= ST_OUT;
                            end
                        end
                        else
                        begin
                            row_reg <= rd_row;
                            if (miss_cnt_reg != sacp_pkg::CNT_MAX)
                            begin
                                miss_cnt_reg <= miss_cnt_reg + 32'd1;
                            end
                            pf_left_reg <= pf_used;
                            state_reg   <= ST_EVICT;
                        end
                    end
                    else if (look_hit)
                    begin
                        row_reg   <= rd_row;
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        row_reg   <= rd_row;
                        state_reg <= ST_EVICT;
                    end
                end
                ST_EVICT:
                begin
                    if (old_found && 32'(vcount) >= 32'(ways_used))
                    begin
                        row_reg[old_way].valid <= 1'b0;
                    end
                    else
                    begin
                        row_reg <= ins_row;
                        reads_reg <= reads_reg + 4'd1;
                        if (read_cnt_reg != sacp_pkg::CNT_MAX)
                        begin
                            read_cnt_reg <= read_cnt_reg + 32'd1;
                        end
                        state_reg <= ST_WRITE;
                    end
                end
                ST_WRITE:
                begin
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    // Next prefetch lookup, or deliver once the output is free.
                    if (pf_next)
                    begin
                        pf_left_reg <= pf_left_reg - 6'd1;
                        addr_reg    <= addr_reg + (ADDR_BITS'(1) << offset_bits_reg);
                        demand_reg  <= 1'b0;
                        state_reg   <= ST_READ;
                    end
                    else if (out_load)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {3'd0, write_cnt_reg, read_cnt_reg,
                                          miss_cnt_reg, hit_cnt_reg, reads_reg, hit_reg};
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // A transfer is taken only when idle and never during the clearing pass.
    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !s_axis_tready)
        else $error("input taken during clearing pass");

    // A waiting result is never overwritten.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result overwritten while stalled");

    // A demand hit causes no memory read.
    a_hit_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[4:1] == 4'd0))
        else $error("hit with reads");

endmodule

// ===== tb/sv/tb_set_assoc_cache_with_prefetch.sv =====
`timescale 1ns / 1ps

module tb_set_assoc_cache_with_prefetch;

    localparam int NSETS     = 1 << 10;
    localparam int NWAYS     = 8;
    localparam int PF_MAX    = 8;
    localparam int IDX_MAX   = 10;
    localparam logic [47:0] ADDR_ONES = 48'hFFFF_FFFF_FFFF;
    localparam logic [4:0] PADDR_UNUSED = 5'd20;

    // Idling modes of a phase.
    localparam int IDLE_NONE   = 0;
    localparam int IDLE_SEND   = 1;
    localparam int IDLE_RECV   = 2;
    localparam int IDLE_BOTH   = 3;

    // Fields listed from the highest bit down, so hit lands in bit 0.
    typedef struct packed {
        logic [31:0] writes;
        logic [31:0] mem_reads;
        logic [31:0] misses;
        logic [31:0] hits;
        logic [3:0]  reads;
        logic        hit;
    } access_result_t;

    typedef struct {
        logic [47:0] addr;
        logic        cmd;
        bit          typed;
        logic        hit;
        logic [3:0]  reads;
    } access_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // tdata: address[47:0], cmd[48], zero fill up to bit 55
    logic [55:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // tdata: hit[0], reads_caused[4:1], hit_total[36:5], miss_total[68:37],
    // read_total[100:69], write_total[132:101], zero fill up to bit 135
    logic [135:0] m_axis_tdata;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    set_assoc_cache_with_prefetch uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Shadow copy of the cache state and the registers.
    logic [47:0] shadow_tag   [NSETS*NWAYS];
    bit          shadow_valid [NSETS*NWAYS];
    logic [2:0]  shadow_age   [NSETS*NWAYS];
    logic [31:0] cnt_hit, cnt_miss, cnt_read, cnt_write;
    logic [4:0]  cfg_offset;
    logic [3:0]  cfg_index;
    logic [3:0]  cfg_ways;
    logic        cfg_policy;
    logic [3:0]  cfg_prefetch;

    access_result_t pending_results[$];
    int  mismatches;
    int  idle_mode;
    logic [47:0] region_base;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("tb_set_assoc_cache_with_prefetch: FAIL");
        $finish;
    end

    function automatic int eff_index();
        return (cfg_index > IDX_MAX) ? IDX_MAX : int'(cfg_index);
    endfunction

    function automatic int set_base(logic [47:0] addr);
        logic [47:0] blk;
        blk = addr >> cfg_offset;
        return int'(blk & ((48'd1 << eff_index()) - 48'd1)) * NWAYS;
    endfunction

    function automatic logic [47:0] tag_of(logic [47:0] addr);
        return addr >> (cfg_offset + eff_index());
    endfunction

    function automatic void bump(ref logic [31:0] c);
        if (c != sacp_pkg::CNT_MAX)
            c = c + 32'd1;
    endfunction

    // Tag search; a demand hit under LRU makes the line the newest.
    function automatic bit probe(logic [47:0] addr, bit demand);
        int b;
        int i;
        logic [47:0] t;
        logic [2:0] a;
        b = set_base(addr);
        t = tag_of(addr);
        for (int w = 0; w < NWAYS; w++)
        begin
            i = b + w;
            if (shadow_valid[i] && shadow_tag[i] == t)
            begin
                if (demand && cfg_policy == sacp_pkg::POLICY_LRU)
                begin
                    a = shadow_age[i];
                    for (int k = 0; k < NWAYS; k++)
                        if (shadow_valid[b+k] && shadow_age[b+k] < a)
                            shadow_age[b+k] = shadow_age[b+k] + 3'd1;
                    shadow_age[i] = 3'd0;
                end
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Insertion, evicting the oldest lines until there is room.
    function automatic void fill_line(logic [47:0] addr);
        int b;
        int ways;
        int count;
        int old;
        int slot;
        b = set_base(addr);
        ways = (cfg_ways == 0) ? 1 : ((cfg_ways > NWAYS) ? NWAYS : int'(cfg_ways));
        count = 0;
        slot = 0;
        for (int w = 0; w < NWAYS; w++)
            if (shadow_valid[b+w])
                count++;
        while (count >= ways)
        begin
            old = NWAYS;
            for (int w = 0; w < NWAYS; w++)
                if (shadow_valid[b+w] &&
                    (old == NWAYS || shadow_age[b+w] > shadow_age[b+old]))
                    old = w;
            if (old == NWAYS)
                break;
            shadow_valid[b+old] = 1'b0;
            count--;
        end
        for (int w = 0; w < NWAYS; w++)
            if (shadow_valid[b+w])
                shadow_age[b+w] = shadow_age[b+w] + 3'd1;
        for (int w = NWAYS - 1; w >= 0; w--)
            if (!shadow_valid[b+w])
                slot = w;
        shadow_valid[b+slot] = 1'b1;
        shadow_tag[b+slot]   = tag_of(addr);
        shadow_age[b+slot]   = 3'd0;
    endfunction

    // Works out the result of one access and advances the shadow state.
    function automatic access_result_t predict_access(logic [47:0] addr, logic cmd);
        access_result_t r;
        int n;
        logic [47:0] a;
        a = addr;
        r.reads = 4'd0;
        if (cmd)
            bump(cnt_write);
        r.hit = probe(a, 1'b1);
        if (r.hit)
            bump(cnt_hit);
        else
        begin
            n = (cfg_prefetch > PF_MAX) ? PF_MAX : int'(cfg_prefetch);
            bump(cnt_miss);
            bump(cnt_read);
            r.reads = 4'd1;
            fill_line(a);
            for (int i = 0; i < n; i++)
            begin
                a = a + (48'd1 << cfg_offset);
                if (!probe(a, 1'b0))
                begin
                    bump(cnt_read);
                    r.reads = r.reads + 4'd1;
                    fill_line(a);
                end
            end
        end
        r.hits      = cnt_hit;
        r.misses    = cnt_miss;
        r.mem_reads = cnt_read;
        r.writes    = cnt_write;
        return r;
    endfunction

    function automatic bit sender_pauses();
        case (idle_mode)
            IDLE_SEND: return $urandom_range(0, 99) < 64;
            IDLE_BOTH: return $urandom_range(0, 99) < 37;
            default:   return 1'b0;
        endcase
    endfunction

    // Mostly addresses near a per-phase base so that lines are reused.
    function automatic logic [47:0] pick_address();
        logic [47:0] low;
        int sel;
        sel = $urandom_range(0, 9);
        low = 48'({$urandom, $urandom});
        if (sel == 0)
            return low;
        if (sel == 1)
            return ADDR_ONES - 48'($urandom_range(0, 255));
        low = low & ((48'd1 << cfg_offset) - 48'd1);
        return region_base + (48'($urandom_range(0, 47)) << cfg_offset) + low;
    endfunction

    // One transfer on the input side, with random gaps before it.
    task automatic send_access(logic [47:0] addr, logic cmd, access_result_t exp_r);
        @(negedge clk);
        while (sender_pauses())
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {7'd0, cmd, addr};
        pending_results.push_back(exp_r);
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic drain();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    task automatic apb_write(logic [4:0] addr, logic [31:0] data);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Programs all five registers and the shadow copy alike.
    task automatic configure(logic [4:0] off, logic [3:0] idx, logic [3:0] ways,
                             logic pol, logic [3:0] pf);
        apb_write(5'(sacp_pkg::REG_OFFSET) << 2, 32'(off));
        apb_write(5'(sacp_pkg::REG_INDEX) << 2, 32'(idx));
        apb_write(5'(sacp_pkg::REG_WAYS) << 2, 32'(ways));
        apb_write(5'(sacp_pkg::REG_POLICY) << 2, 32'(pol));
        apb_write(5'(sacp_pkg::REG_PREFETCH) << 2, 32'(pf));
        cfg_offset   = off;
        cfg_index    = idx;
        cfg_ways     = ways;
        cfg_policy   = pol;
        cfg_prefetch = pf;
    endtask

    // Receiver stalls, changed at the falling edge.
    always @(negedge clk)
    begin
        case (idle_mode)
            IDLE_RECV: m_axis_tready <= ($urandom_range(0, 99) >= 64);
            IDLE_BOTH: m_axis_tready <= ($urandom_range(0, 99) >= 37);
            default:   m_axis_tready <= 1'b1;
        endcase
    end

    // Result checking against the oldest waiting expectation.
    always @(posedge clk)
    begin
        access_result_t got;
        access_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[132:0];
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: %h", got);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.hit !== want.hit || got.reads !== want.reads ||
                    got.hits !== want.hits || got.misses !== want.misses ||
                    got.mem_reads !== want.mem_reads || got.writes !== want.writes)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result mismatch: exp hit=%0d reads=%0d %0d/%0d/%0d/%0d,",
                                  " got hit=%0d reads=%0d %0d/%0d/%0d/%0d"},
                                 want.hit, want.reads, want.hits, want.misses,
                                 want.mem_reads, want.writes, got.hit, got.reads,
                                 got.hits, got.misses, got.mem_reads, got.writes);
                end
            end
        end
    end

    initial
    begin
        access_row_t rows[$];
        access_result_t r;
        logic [47:0] a;
        logic c;
        int phase_cfg[10][5];

        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        m_axis_tready = 1'b1;
        idle_mode  = IDLE_NONE;
        mismatches = 0;
        region_base = '0;
        cnt_hit = 0;
        cnt_miss = 0;
        cnt_read = 0;
        cnt_write = 0;
        cfg_offset = 5'd6;
        cfg_index = 4'd6;
        cfg_ways = 4'd1;
        cfg_policy = sacp_pkg::POLICY_FIFO;
        cfg_prefetch = 4'd0;
        for (int i = 0; i < NSETS*NWAYS; i++)
        begin
            shadow_valid[i] = 1'b0;
            shadow_age[i]   = 3'd0;
            shadow_tag[i]   = '0;
        end
        rst_n = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // Directed accesses under the reset settings (one way, no prefetch).
        rows = '{
            '{48'h0,             1'b0, 1'b1, 1'b0, 4'd1},
            '{48'h0,             1'b1, 1'b1, 1'b1, 4'd0},
            '{48'h3F,            1'b0, 1'b1, 1'b1, 4'd0},
            '{48'h40,            1'b1, 1'b1, 1'b0, 4'd1},
            '{ADDR_ONES,         1'b0, 1'b1, 1'b0, 4'd1},
            '{ADDR_ONES,         1'b1, 1'b1, 1'b1, 4'd0},
            '{48'h1000,          1'b0, 1'b1, 1'b0, 4'd1},
            '{48'h0,             1'b0, 1'b1, 1'b0, 4'd1},
            '{48'h8000_0000_0000, 1'b1, 1'b0, 1'b0, 4'd0},
            '{48'h7FFF_FFFF_FFFF, 1'b0, 1'b0, 1'b0, 4'd0},
            '{48'h5555_5555_5555, 1'b1, 1'b0, 1'b0, 4'd0},
            '{48'hAAAA_AAAA_AAAA, 1'b0, 1'b0, 1'b0, 4'd0}
        };
        foreach (rows[i])
        begin
            r = predict_access(rows[i].addr, rows[i].cmd);
            if (rows[i].typed)
            begin
                r.hit   = rows[i].hit;
                r.reads = rows[i].reads;
            end
            send_access(rows[i].addr, rows[i].cmd, r);
        end
        drain();

        // A write to an unused address must leave every register alone.
        apb_write(PADDR_UNUSED, 32'hFFFF_FFFF);
        a = ADDR_ONES - 48'h20;
        configure(5'd4, 4'd2, 4'd4, sacp_pkg::POLICY_LRU, 4'd8);
        // Prefetch running past the top of the address space wraps to zero.
        r = predict_access(a, 1'b0);
        send_access(a, 1'b0, r);
        r = predict_access(48'h0, 1'b0);
        send_access(48'h0, 1'b0, r);
        drain();

        // Settings per phase: offset, index, ways, policy, prefetch.
        phase_cfg = '{
            '{6, 6, 1, 0, 0}, '{0, 0, 8, 1, 8}, '{16, 10, 8, 0, 8},
            '{4, 15, 15, 1, 15}, '{6, 3, 0, 0, 2}, '{5, 2, 8, 1, 3},
            '{5, 2, 2, 1, 1}, '{31, 4, 4, 0, 4}, '{2, 1, 3, 1, 0},
            '{3, 3, 6, 0, 1}
        };
        for (int p = 0; p < 10; p++)
        begin
            configure(5'(phase_cfg[p][0]), 4'(phase_cfg[p][1]), 4'(phase_cfg[p][2]),
                      1'(phase_cfg[p][3]), 4'(phase_cfg[p][4]));
            idle_mode = p % 4;
            region_base = 48'({$urandom, $urandom});
            for (int n = 0; n < 84; n++)
            begin
                if (n == 42)
                    idle_mode = (idle_mode + 1) % 4;
                a = pick_address();
                c = 1'($urandom);
                r = predict_access(a, c);
                send_access(a, c, r);
            end
            // Let the phase finish before the registers change.
            drain();
        end

        idle_mode = IDLE_NONE;
        drain();
        if (mismatches == 0)
            $display("tb_set_assoc_cache_with_prefetch: PASS");
        else
            $display("tb_set_assoc_cache_with_prefetch: FAIL");
        $finish;
    end

endmodule
